FILE: rtl/sdpp_pkg.sv
// Package for the SMS-DELIVER PDU parser: phase codes, result kinds, status codes,
// result record and small helpers. No dependencies.
package sdpp_pkg;

  localparam int MaxRes  = 4;   // results one octet can cause
  localparam int QDepth  = 8;   // result queue slots
  localparam int QCntW   = $clog2(QDepth + 1);
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFirstMask  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSenderSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTextSize   = 2'd2;

  localparam logic [7:0] FirstMaskRst  = 8'd4;
  localparam logic [8:0] SenderSizeRst = 9'd21;
  localparam logic [8:0] TextSizeRst   = 9'd161;

  // result kinds
  localparam logic [1:0] KindDigit = 2'd0;
  localparam logic [1:0] KindTime  = 2'd1;
  localparam logic [1:0] KindText  = 2'd2;
  localparam logic [1:0] KindEnd   = 2'd3;

  // end status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StTruncated  = 3'd1;
  localparam logic [2:0] StBadFirst   = 3'd2;
  localparam logic [2:0] StSenderLong = 3'd3;
  localparam logic [2:0] StTextLong   = 3'd4;
  localparam logic [2:0] StTextShort  = 3'd5;

  localparam logic [7:0] AsciiZero   = 8'h30;
  localparam logic [7:0] TimeFields  = 8'd7;

  typedef enum logic [3:0] {
    PH_SCA_LEN,
    PH_SCA_SKIP,
    PH_FIRST,
    PH_SND_LEN,
    PH_TOA,
    PH_DIGITS,
    PH_PID,
    PH_DCS,
    PH_TIME,
    PH_TXT_LEN,
    PH_TEXT,
    PH_DONE,
    PH_DISCARD
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] position;
    logic [2:0] status;
    logic       last_of_item;
  } res_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] value,
                                  logic [7:0] position, logic [2:0] status);
    res_t r;
    r.kind         = kind;
    r.value        = value;
    r.position     = position;
    r.status       = status;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  // swapped BCD: high nibble is the units digit, low nibble the tens digit
  function automatic logic [7:0] swapped_bcd(logic [7:0] b);
    return {4'd0, b[7:4]} + {1'b0, b[3:0], 3'd0} + {3'd0, b[3:0], 1'b0};
  endfunction

endpackage

FILE: rtl/sdpp_if.sv
// Valid/ready channels of the SMS-DELIVER PDU parser: octet input and result output.
// No dependencies.
interface sdpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_pdu;

  modport source (output valid, output data_byte, output end_of_pdu, input ready);
  modport sink   (input valid, input data_byte, input end_of_pdu, output ready);
endinterface

interface sdpp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [7:0] position;
  logic [2:0] status;
  logic       last_of_item;

  modport source (output valid, output kind, output value, output position,
                  output status, output last_of_item, input ready);
  modport sink   (input valid, input kind, input value, input position,
                  input status, input last_of_item, output ready);
endinterface

FILE: rtl/sms_deliver_pdu_parser_core.sv
// SMS-DELIVER PDU parser top level: octet decoder and result queue.
// Depends on sdpp_pkg and the channel interfaces in sdpp_if.sv.
//
//  channel  | dir | payload                                         | request
//  in_ch    | in  | data_byte, end_of_pdu                           | one PDU octet
//  out_ch   | out | kind, value, position, status, last_of_item    | one result
//  cfg_*    | in  | cfg_index, cfg_data                             | register write
//
// Each octet is decoded in the cycle it is taken; its 0 to 4 results enter an
// 8-slot queue and leave one per cycle while out_ch.ready is high, so the output
// port sets the sustained rate.
// in_ch.ready is high while at least 4 queue slots are free.
// Synchronous reset restores the state, configuration and queue count; no clearing pass.
// Output stalls only fill the queue; the input stops once fewer than 4 slots remain.
module sms_deliver_pdu_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sdpp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sdpp_pkg::CfgDataW-1:0] cfg_data,
  sdpp_in_if.sink                       in_ch,
  sdpp_out_if.source                    out_ch
);
  import sdpp_pkg::*;

  // configuration
  logic [7:0] first_octet_mask;
  logic [8:0] sender_buffer_size;
  logic [8:0] text_buffer_size;

  // parser state
  phase_t     phase, phase_next;
  logic [7:0] field_countdown, field_countdown_next;
  logic [7:0] sender_digits, sender_digits_next;
  logic [7:0] digit_index, digit_index_next;
  logic [7:0] text_length, text_length_next;
  logic [7:0] char_count, char_count_next;
  logic [7:0] previous_byte, previous_byte_next;
  logic [2:0] carry_bits, carry_bits_next;
  logic       text_started, text_started_next;

  // results of the current octet
  res_t       r [MaxRes];
  logic [2:0] n;
  logic [7:0] b;
  logic [7:0] low_part;
  logic [7:0] sept;

  // result queue
  res_t             q [QDepth];
  res_t             q_next [QDepth];
  logic [QCntW-1:0] cnt, cnt_next, base;

  logic accept, pop;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign b      = in_ch.data_byte;

  assign in_ch.ready         = (cnt <= QCntW'(QDepth - MaxRes));
  assign out_ch.valid        = (cnt != '0);
  assign out_ch.kind         = q[0].kind;
  assign out_ch.value        = q[0].value;
  assign out_ch.position     = q[0].position;
  assign out_ch.status       = q[0].status;
  assign out_ch.last_of_item = q[0].last_of_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_octet_mask   <= FirstMaskRst;
      sender_buffer_size <= SenderSizeRst;
      text_buffer_size   <= TextSizeRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgFirstMask:  first_octet_mask   <= cfg_data[7:0];
        CfgSenderSize: sender_buffer_size <= cfg_data;
        CfgTextSize:   text_buffer_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode one octet; the end-of-PDU appends are guarded against a fifth result
  always_comb begin
    phase_next           = phase;
    field_countdown_next = field_countdown;
    sender_digits_next   = sender_digits;
    digit_index_next     = digit_index;
    text_length_next     = text_length;
    char_count_next      = char_count;
    previous_byte_next   = previous_byte;
    carry_bits_next      = carry_bits;
    text_started_next    = text_started;
    n        = 3'd0;
    low_part = 8'd0;
    sept     = 8'd0;
    for (int i = 0; i < MaxRes; i++) r[i] = '0;

    case (phase)
      PH_SCA_LEN: begin
        field_countdown_next = b;
        phase_next = (b == 8'd0) ? PH_FIRST : PH_SCA_SKIP;
      end
      PH_SCA_SKIP: begin
        field_countdown_next = field_countdown - 8'd1;
        if (field_countdown_next == 8'd0) phase_next = PH_FIRST;
      end
      PH_FIRST: begin
        if ((b & first_octet_mask) != first_octet_mask) begin
          r[0] = mk_res(KindEnd, 8'd0, 8'd0, StBadFirst);
          n = 3'd1;
          phase_next = PH_DISCARD;
        end else begin
          phase_next = PH_SND_LEN;
        end
      end
      PH_SND_LEN: begin
        sender_digits_next = b;
        if ({1'b0, b} + 9'd1 > sender_buffer_size) begin
          r[0] = mk_res(KindEnd, 8'd0, 8'd0, StSenderLong);
          n = 3'd1;
          phase_next = PH_DISCARD;
        end else begin
          phase_next = PH_TOA;
        end
      end
      PH_TOA: begin
        digit_index_next     = 8'd0;
        field_countdown_next = 8'(({1'b0, sender_digits} + 9'd1) >> 1);
        phase_next = (field_countdown_next == 8'd0) ? PH_PID : PH_DIGITS;
      end
      PH_DIGITS: begin
        if (digit_index_next < sender_digits) begin
          r[n[1:0]] = mk_res(KindDigit, {4'd0, b[3:0]} + AsciiZero, digit_index_next, StOk);
          n = n + 3'd1;
          digit_index_next = digit_index_next + 8'd1;
        end
        if (digit_index_next < sender_digits) begin
          r[n[1:0]] = mk_res(KindDigit, {4'd0, b[7:4]} + AsciiZero, digit_index_next, StOk);
          n = n + 3'd1;
          digit_index_next = digit_index_next + 8'd1;
        end
        field_countdown_next = field_countdown - 8'd1;
        if (field_countdown_next == 8'd0) phase_next = PH_PID;
      end
      PH_PID: phase_next = PH_DCS;
      PH_DCS: begin
        field_countdown_next = TimeFields;
        phase_next = PH_TIME;
      end
      PH_TIME: begin
        r[0] = mk_res(KindTime, swapped_bcd(b), TimeFields - field_countdown, StOk);
        n = 3'd1;
        field_countdown_next = field_countdown - 8'd1;
        if (field_countdown_next == 8'd0) phase_next = PH_TXT_LEN;
      end
      PH_TXT_LEN: begin
        text_length_next = b;
        if (text_buffer_size < {1'b0, b}) begin
          r[0] = mk_res(KindEnd, 8'd0, 8'd0, StTextLong);
          n = 3'd1;
          phase_next = PH_DISCARD;
        end else begin
          char_count_next   = 8'd0;
          carry_bits_next   = 3'd1;
          text_started_next = 1'b0;
          phase_next = (b == 8'd0) ? PH_DONE : PH_TEXT;
        end
      end
      PH_TEXT: begin
        if (!text_started) begin
          text_started_next = 1'b1;
          r[0] = mk_res(KindText, {1'b0, b[6:0]}, char_count_next, StOk);
          n = 3'd1;
          char_count_next = char_count_next + 8'd1;
          if (char_count_next == text_length) phase_next = PH_DONE;
        end else begin
          // septet = new bits shifted up over the leftover top bits of the last octet
          low_part = previous_byte >> (4'd8 - {1'b0, carry_bits});
          sept     = 8'(b << carry_bits) | low_part;
          r[0] = mk_res(KindText, {1'b0, sept[6:0]}, char_count_next, StOk);
          n = 3'd1;
          char_count_next = char_count_next + 8'd1;
          if (char_count_next == text_length) phase_next = PH_DONE;
          if (phase_next == PH_TEXT) begin
            if (carry_bits == 3'd7) begin
              // seven octets hold eight septets: the last one is the octet's low seven bits
              carry_bits_next = 3'd1;
              r[1] = mk_res(KindText, {1'b0, b[6:0]}, char_count_next, StOk);
              n = 3'd2;
              char_count_next = char_count_next + 8'd1;
              if (char_count_next == text_length) phase_next = PH_DONE;
            end else begin
              carry_bits_next = carry_bits + 3'd1;
            end
          end
        end
        previous_byte_next = b;
      end
      default: ;
    endcase

    if (in_ch.end_of_pdu) begin
      if (phase_next == PH_DONE) begin
        if (!n[2]) begin
          r[n[1:0]] = mk_res(KindEnd, char_count_next, 8'd0, StOk);
          n = n + 3'd1;
        end
      end else if (phase_next == PH_TEXT) begin
        if (!text_started_next) begin
          if (!n[2]) begin
            r[n[1:0]] = mk_res(KindEnd, char_count_next, 8'd0, StTruncated);
            n = n + 3'd1;
          end
        end else begin
          // flush the remaining top bits of the last octet as one more septet
          if (char_count_next < text_length_next) begin
            if (!n[2]) begin
              r[n[1:0]] = mk_res(KindText,
                                 previous_byte_next >> (4'd8 - {1'b0, carry_bits_next}),
                                 char_count_next, StOk);
              n = n + 3'd1;
            end
            char_count_next = char_count_next + 8'd1;
          end
          if (!n[2]) begin
            r[n[1:0]] = mk_res(KindEnd, char_count_next, 8'd0,
                               (char_count_next == text_length_next) ? StOk : StTextShort);
            n = n + 3'd1;
          end
        end
      end else if (phase_next != PH_DISCARD) begin
        if (!n[2]) begin
          r[n[1:0]] = mk_res(KindEnd, char_count_next, 8'd0, StTruncated);
          n = n + 3'd1;
        end
      end
      phase_next           = PH_SCA_LEN;
      field_countdown_next = 8'd0;
      sender_digits_next   = 8'd0;
      digit_index_next     = 8'd0;
      text_length_next     = 8'd0;
      char_count_next      = 8'd0;
      previous_byte_next   = 8'd0;
      carry_bits_next      = 3'd1;
      text_started_next    = 1'b0;
    end

    for (int j = 0; j < MaxRes; j++) begin
      r[j].last_of_item = ({1'b0, n} == 4'(j + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SCA_LEN;
      field_countdown <= 8'd0;
      sender_digits   <= 8'd0;
      digit_index     <= 8'd0;
      text_length     <= 8'd0;
      char_count      <= 8'd0;
      previous_byte   <= 8'd0;
      carry_bits      <= 3'd1;
      text_started    <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      field_countdown <= field_countdown_next;
      sender_digits   <= sender_digits_next;
      digit_index     <= digit_index_next;
      text_length     <= text_length_next;
      char_count      <= char_count_next;
      previous_byte   <= previous_byte_next;
      carry_bits      <= carry_bits_next;
      text_started    <= text_started_next;
    end
  end

  // shift queue: advance on pop, append the octet's results behind what remains
  always_comb begin
    base     = cnt - QCntW'(pop);
    cnt_next = base + (accept ? QCntW'(n) : '0);
    for (int i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) q_next[i] = q[i + 1];
      else                       q_next[i] = q[i];
      for (int j = 0; j < MaxRes; j++) begin
        if (accept && (4'(j) < {1'b0, n}) && (QCntW'(i) == base + QCntW'(j))) begin
          q_next[i] = r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else     cnt <= cnt_next;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) q[i] <= q_next[i];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= QCntW'(QDepth))
    else $error("result queue overfilled");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.end_of_pdu) |=> (phase == PH_SCA_LEN && carry_bits == 3'd1))
    else $error("parser not back at start after end of PDU");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind == KindEnd) |-> out_ch.last_of_item)
    else $error("end status is not the last result of its octet");

  a_carry_nonzero: assert property (@(posedge clk) disable iff (rst)
    carry_bits != 3'd0)
    else $error("septet carry count out of range");

endmodule

FILE: verif/testbench.sv
// Self-checking bench for the SMS-DELIVER PDU parser core: octet requests in, result
// records out, checked in order against a cycle-free decoder model held in this file.
// Depends on sdpp_pkg, the channel interfaces in sdpp_if.sv and the core itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdpp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } pdu_octet_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  sdpp_in_if  in_if ();
  sdpp_out_if out_if ();

  sms_deliver_pdu_parser_core uut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  pdu_octet_t pending_octets[$];
  pdu_octet_t next_octet;
  res_t       expected_results[$];
  res_t       want;
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  // register copies
  logic [7:0] first_mask;
  logic [8:0] sender_limit;
  logic [8:0] text_limit;

  // decoder state
  phase_t     dec_phase;
  logic [7:0] countdown;
  logic [7:0] sender_len;
  logic [7:0] digit_idx;
  logic [7:0] text_len;
  logic [7:0] septet_count;
  logic [7:0] prev_octet;
  logic [3:0] carry;
  logic       text_begun;
  int         step_results;

  // bit 8 marks the end of a PDU
  logic [8:0] directed_stream [0:21] = '{
    9'h000, 9'h100,                         // first octet misses the mask
    9'h1FF,                                 // PDU ends on the address length
    9'h000, 9'h004, 9'h0FF, 9'h100,         // sender too long, tail dropped
    9'h000, 9'h004, 9'h000, 9'h091, 9'h000, 9'h000,
    9'h000, 9'h0FF, 9'h099, 9'h010, 9'h001, 9'h05A, 9'h0A5,
    9'h002, 9'h1C8                          // second septet comes from the remainder
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic start_pdu();
    dec_phase    = PH_SCA_LEN;
    countdown    = '0;
    sender_len   = '0;
    digit_idx    = '0;
    text_len     = '0;
    septet_count = '0;
    prev_octet   = '0;
    carry        = 4'd1;
    text_begun   = 1'b0;
  endtask

  function automatic void emit(logic [1:0] k, logic [7:0] v, logic [7:0] p, logic [2:0] s);
    res_t r;
    if (step_results < MaxRes) begin
      r.kind         = k;
      r.value        = v;
      r.position     = p;
      r.status       = s;
      r.last_of_item = 1'b0;
      expected_results.push_back(r);
      step_results++;
    end
  endfunction

  function automatic void emit_septet(logic [7:0] v);
    emit(KindText, {1'b0, v[6:0]}, septet_count, StOk);
    septet_count++;
    if (septet_count == text_len) dec_phase = PH_DONE;
  endfunction

  task automatic decode_octet(logic [7:0] b, logic eop);
    logic [7:0] v;
    logic [8:0] half;
    step_results = 0;
    case (dec_phase)
      PH_SCA_LEN: begin
        countdown = b;
        if (b == 8'd0) dec_phase = PH_FIRST;
        else dec_phase = PH_SCA_SKIP;
      end
      PH_SCA_SKIP: begin
        countdown--;
        if (countdown == 8'd0) dec_phase = PH_FIRST;
      end
      PH_FIRST: begin
        if ((b & first_mask) != first_mask) begin
          emit(KindEnd, 8'd0, 8'd0, StBadFirst);
          dec_phase = PH_DISCARD;
        end else begin
          dec_phase = PH_SND_LEN;
        end
      end
      PH_SND_LEN: begin
        sender_len = b;
        if ({1'b0, b} + 9'd1 > sender_limit) begin
          emit(KindEnd, 8'd0, 8'd0, StSenderLong);
          dec_phase = PH_DISCARD;
        end else begin
          dec_phase = PH_TOA;
        end
      end
      PH_TOA: begin
        digit_idx = '0;
        half = ({1'b0, sender_len} + 9'd1) >> 1;
        countdown = half[7:0];
        if (countdown == 8'd0) dec_phase = PH_PID;
        else dec_phase = PH_DIGITS;
      end
      PH_DIGITS: begin
        // low nibble first; a padding nibble past the count is dropped
        if (digit_idx < sender_len) begin
          emit(KindDigit, {4'd0, b[3:0]} + AsciiZero, digit_idx, StOk);
          digit_idx++;
        end
        if (digit_idx < sender_len) begin
          emit(KindDigit, {4'd0, b[7:4]} + AsciiZero, digit_idx, StOk);
          digit_idx++;
        end
        countdown--;
        if (countdown == 8'd0) dec_phase = PH_PID;
      end
      PH_PID: dec_phase = PH_DCS;
      PH_DCS: begin
        countdown = TimeFields;
        dec_phase = PH_TIME;
      end
      PH_TIME: begin
        emit(KindTime, {4'd0, b[7:4]} + {4'd0, b[3:0]} * 8'd10, TimeFields - countdown, StOk);
        countdown--;
        if (countdown == 8'd0) dec_phase = PH_TXT_LEN;
      end
      PH_TXT_LEN: begin
        text_len = b;
        if (text_limit < {1'b0, b}) begin
          emit(KindEnd, 8'd0, 8'd0, StTextLong);
          dec_phase = PH_DISCARD;
        end else begin
          septet_count = '0;
          carry        = 4'd1;
          text_begun   = 1'b0;
          if (b == 8'd0) dec_phase = PH_DONE;
          else dec_phase = PH_TEXT;
        end
      end
      PH_TEXT: begin
        if (!text_begun) begin
          text_begun = 1'b1;
          emit_septet(b);
        end else begin
          v = (b << carry) | (prev_octet >> (4'd8 - carry));
          emit_septet(v);
          if (dec_phase == PH_TEXT) begin
            carry++;
            // every seventh octet carries one more whole septet
            if (carry >= 4'd8) begin
              carry = 4'd1;
              emit_septet(b);
            end
          end
        end
        prev_octet = b;
      end
      default: ;
    endcase

    if (eop) begin
      case (dec_phase)
        PH_DONE: emit(KindEnd, septet_count, 8'd0, StOk);
        PH_TEXT: begin
          if (!text_begun) begin
            emit(KindEnd, septet_count, 8'd0, StTruncated);
          end else begin
            // flush the leftover high bits of the last octet as one more septet
            if (septet_count < text_len) begin
              emit(KindText, prev_octet >> (4'd8 - carry), septet_count, StOk);
              septet_count++;
            end
            emit(KindEnd, septet_count, 8'd0,
                 (septet_count == text_len) ? StOk : StTextShort);
          end
        end
        PH_DISCARD: ;
        default: emit(KindEnd, septet_count, 8'd0, StTruncated);
      endcase
      start_pdu();
    end

    if (step_results > 0)
      expected_results[expected_results.size() - 1].last_of_item = 1'b1;
  endtask

  task automatic compare_field(string label, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, label, expv, actv);
    end
  endtask

  task automatic push_octet(logic [7:0] d, logic e);
    pending_octets.push_back({d, e});
  endtask

  // one PDU, mostly well formed, with random content and the odd broken tail
  task automatic queue_pdu(output int count);
    logic [7:0] pdu [$];
    logic [7:0] sca_len;
    logic [7:0] digits;
    logic [7:0] tlen;
    int         octets;
    int         style;
    int         cut;
    style = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) sca_len = 8'($urandom_range(3, 12));
    else sca_len = 8'($urandom_range(0, 2));
    pdu.push_back(sca_len);
    repeat (sca_len) pdu.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0) pdu.push_back(8'($urandom));
    else pdu.push_back(8'($urandom) | first_mask);
    if ($urandom_range(0, 19) == 0) digits = 8'($urandom_range(10, 255));
    else digits = 8'($urandom_range(0, 9));
    pdu.push_back(digits);
    if ({1'b0, digits} + 9'd1 > sender_limit) begin
      repeat ($urandom_range(0, 3)) pdu.push_back(8'($urandom));
    end else begin
      repeat ((digits + 1) / 2 + 10) pdu.push_back(8'($urandom));  // type, digits, PID, DCS, time
      if ($urandom_range(0, 9) == 0) tlen = 8'($urandom);
      else tlen = 8'($urandom_range(0, 12));
      pdu.push_back(tlen);
      if ({1'b0, tlen} > text_limit) begin
        repeat ($urandom_range(0, 3)) pdu.push_back(8'($urandom));
      end else begin
        octets = (7 * tlen + 7) / 8;
        if (style >= 65 && style < 75) octets = $urandom_range(0, octets);
        else if (style >= 75 && style < 85) octets += $urandom_range(1, 3);
        repeat (octets) pdu.push_back(8'($urandom));
      end
    end
    if (style >= 85) begin
      cut = $urandom_range(1, pdu.size());
      while (pdu.size() > cut) void'(pdu.pop_back());
    end
    foreach (pdu[i]) push_octet(pdu[i], i == pdu.size() - 1);
    count = pdu.size();
  endtask

  task automatic wait_idle();
    while (pending_octets.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CfgFirstMask:  first_mask   = val[7:0];
      CfgSenderSize: sender_limit = val;
      CfgTextSize:   text_limit   = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [7:0] mask, logic [8:0] snd, logic [8:0] txt,
                           int send_pct, int recv_pct, int budget);
    int queued;
    int n;
    queued = 0;
    wait_idle();
    write_reg(CfgFirstMask, {1'b0, mask});
    write_reg(CfgSenderSize, snd);
    write_reg(CfgTextSize, txt);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (queued < budget) begin
      queue_pdu(n);
      queued += n;
    end
  endtask

  // driver: predict on acceptance, hold the request while the parser is full
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) decode_octet(in_if.data_byte, in_if.end_of_pdu);
      if (!in_if.valid || in_if.ready) begin
        if (pending_octets.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_octet = pending_octets.pop_front();
          in_if.valid      <= 1'b1;
          in_if.data_byte  <= next_octet.data;
          in_if.end_of_pdu <= next_octet.eop;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: results must arrive in prediction order
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result kind %0d value %0d position %0d status %0d last %0d",
                   $time, out_if.kind, out_if.value, out_if.position, out_if.status,
                   out_if.last_of_item);
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", {6'd0, want.kind}, {6'd0, out_if.kind});
          compare_field("value", want.value, out_if.value);
          compare_field("position", want.position, out_if.position);
          compare_field("status", {5'd0, want.status}, {5'd0, out_if.status});
          compare_field("last_of_item", {7'd0, want.last_of_item}, {7'd0, out_if.last_of_item});
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CfgFirstMask;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.end_of_pdu = 1'b0;
    out_if.ready     = 1'b0;
    first_mask       = FirstMaskRst;
    sender_limit     = SenderSizeRst;
    text_limit       = TextSizeRst;
    start_pdu();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_stream[i]) push_octet(directed_stream[i][7:0], directed_stream[i][8]);

    run_phase(8'h00, 9'd256, 9'd256, 67, 0, 35);
    run_phase(8'hFF, 9'd12, 9'd0, 0, 67, 35);
    run_phase(FirstMaskRst, SenderSizeRst, TextSizeRst, 27, 27, 40);
    run_phase(8'($urandom) & 8'($urandom), 9'($urandom_range(1, 12)),
              9'($urandom_range(0, 10)), 0, 0, 35);
    run_phase(8'($urandom_range(0, 7)), 9'd0, 9'd255, 67, 0, 15);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sdpp_pkg.sv
rtl/sdpp_if.sv
rtl/sms_deliver_pdu_parser_core.sv
verif/testbench.sv
